FILE: hw/rtl/ltx_pkg.sv
// Shared types and widths for the two-line intersection pipeline.
// No dependencies; imported by ltx_front, ltx_div and the top level.
package ltx_pkg;

	localparam int unsigned NUM_W = 98;   // signed numerators, Q49.48
	localparam int unsigned DET_W = 65;   // signed determinant, Q32.32
	localparam int unsigned MD_W  = 64;   // determinant magnitude
	localparam int unsigned QW    = 33;   // quotient bits from the divider
	localparam int unsigned NLANE = 3;    // x, y, second parameter

	typedef struct packed {
		logic signed [NUM_W-1:0] xn;
		logic signed [NUM_W-1:0] yn;
		logic signed [NUM_W-1:0] mn;
		logic signed [DET_W-1:0] det;
		logic signed [31:0]      p1x;
		logic signed [31:0]      p1y;
		logic                    par;
	} ltx_front_t;

	typedef struct packed {
		logic signed [31:0] cross_x;
		logic signed [31:0] cross_y;
		logic signed [31:0] param;
		logic               par;
		logic               sat;
	} ltx_res_t;

endpackage

FILE: hw/rtl/ltx_front.sv
// Front end: determinant, adjugate numerators and the scaled point numerators.
// Six register stages, split 33x32 and 34x32 partial products. Uses ltx_pkg.
module ltx_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  logic signed [31:0] p1x,
	input  logic signed [31:0] p1y,
	input  logic signed [31:0] d1x,
	input  logic signed [31:0] d1y,
	input  logic signed [31:0] p2x,
	input  logic signed [31:0] p2y,
	input  logic signed [31:0] d2x,
	input  logic signed [31:0] d2y,
	output logic               out_v,
	output ltx_pkg::ltx_front_t fr
);
	import ltx_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [63:0] ma_s1, mb_s1;
	logic signed [32:0] vx_s1, vy_s1;
	logic signed [31:0] p1x_s1, p1y_s1, d1x_s1, d1y_s1, d2x_s1, d2y_s1;

	logic signed [DET_W-1:0] det_s2;
	logic signed [64:0]      pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [31:0]      p1x_s2, p1y_s2, d1x_s2, d1y_s2;

	logic signed [DET_W-1:0] det_s3;
	logic signed [65:0]      nl_s3, nm_s3;
	logic signed [31:0]      p1x_s3, p1y_s3, d1x_s3, d1y_s3;

	logic signed [64:0]      dxl_s4, dxh_s4, dyl_s4, dyh_s4, nxl_s4, nyl_s4;
	logic signed [65:0]      nxh_s4, nyh_s4;
	logic signed [NUM_W-1:0] mn_s4;
	logic signed [DET_W-1:0] det_s4;
	logic signed [31:0]      p1x_s4, p1y_s4;
	logic                    par_s4;

	logic signed [NUM_W-1:0] xa_s5, xb_s5, ya_s5, yb_s5, mn_s5;
	logic signed [DET_W-1:0] det_s5;
	logic signed [31:0]      p1x_s5, p1y_s5;
	logic                    par_s5;

	ltx_front_t fr_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= d1x * d2y;
			mb_s1  <= d2x * d1y;
			vx_s1  <= 33'(p1x) - 33'(p2x);
			vy_s1  <= 33'(p1y) - 33'(p2y);
			p1x_s1 <= p1x;
			p1y_s1 <= p1y;
			d1x_s1 <= d1x;
			d1y_s1 <= d1y;
			d2x_s1 <= d2x;
			d2y_s1 <= d2y;

			det_s2 <= 65'(ma_s1) - 65'(mb_s1);
			pa_s2  <= d2y_s1 * vx_s1;
			pb_s2  <= d2x_s1 * vy_s1;
			pc_s2  <= d1x_s1 * vy_s1;
			pd_s2  <= d1y_s1 * vx_s1;
			p1x_s2 <= p1x_s1;
			p1y_s2 <= p1y_s1;
			d1x_s2 <= d1x_s1;
			d1y_s2 <= d1y_s1;

			det_s3 <= det_s2;
			nl_s3  <= 66'(pa_s2) - 66'(pb_s2);
			nm_s3  <= 66'(pc_s2) - 66'(pd_s2);
			p1x_s3 <= p1x_s2;
			p1y_s3 <= p1y_s2;
			d1x_s3 <= d1x_s2;
			d1y_s3 <= d1y_s2;

			dxl_s4 <= $signed({1'b0, det_s3[31:0]}) * p1x_s3;
			dxh_s4 <= $signed(det_s3[64:32]) * p1x_s3;
			dyl_s4 <= $signed({1'b0, det_s3[31:0]}) * p1y_s3;
			dyh_s4 <= $signed(det_s3[64:32]) * p1y_s3;
			nxl_s4 <= $signed({1'b0, nl_s3[31:0]}) * d1x_s3;
			nxh_s4 <= $signed(nl_s3[65:32]) * d1x_s3;
			nyl_s4 <= $signed({1'b0, nl_s3[31:0]}) * d1y_s3;
			nyh_s4 <= $signed(nl_s3[65:32]) * d1y_s3;
			mn_s4  <= NUM_W'(nm_s3) <<< 16;
			det_s4 <= det_s3;
			par_s4 <= (det_s3 == '0);
			p1x_s4 <= p1x_s3;
			p1y_s4 <= p1y_s3;

			xa_s5  <= (NUM_W'(dxh_s4) <<< 32) + NUM_W'(dxl_s4);
			xb_s5  <= (NUM_W'(nxh_s4) <<< 32) + NUM_W'(nxl_s4);
			ya_s5  <= (NUM_W'(dyh_s4) <<< 32) + NUM_W'(dyl_s4);
			yb_s5  <= (NUM_W'(nyh_s4) <<< 32) + NUM_W'(nyl_s4);
			mn_s5  <= mn_s4;
			det_s5 <= det_s4;
			par_s5 <= par_s4;
			p1x_s5 <= p1x_s4;
			p1y_s5 <= p1y_s4;

			fr_s6.xn  <= xa_s5 - xb_s5;
			fr_s6.yn  <= ya_s5 - yb_s5;
			fr_s6.mn  <= mn_s5;
			fr_s6.det <= det_s5;
			fr_s6.par <= par_s5;
			fr_s6.p1x <= p1x_s5;
			fr_s6.p1y <= p1y_s5;
		end
	end

	assign out_v = v_s6;
	assign fr    = fr_s6;

endmodule

FILE: hw/rtl/ltx_div.sv
// Three-lane pipelined restoring divider with round-half-away and saturation.
// One prep stage, QW step stages, one result stage. Uses ltx_pkg.
module ltx_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  ltx_pkg::ltx_front_t fr,
	output logic                out_v,
	output ltx_pkg::ltx_res_t   res
);
	import ltx_pkg::*;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} lane_res_t;

	function automatic logic div_ge(input logic [MD_W-1:0] r, input logic b,
			input logic [MD_W-1:0] md);
		div_ge = {r, b} >= {1'b0, md};
	endfunction

	function automatic logic [MD_W-1:0] div_rem(input logic [MD_W-1:0] r, input logic b,
			input logic [MD_W-1:0] md);
		logic [MD_W:0] t;
		t = {r, b};
		if (t >= {1'b0, md})
			div_rem = MD_W'(t - {1'b0, md});
		else
			div_rem = t[MD_W-1:0];
	endfunction

	function automatic lane_res_t div_fin(input logic [QW-1:0] q, input logic [MD_W-1:0] r,
			input logic [MD_W-1:0] md, input logic neg, input logic ovf);
		logic        rnd;
		logic [QW:0] qf, lim, mag;
		lane_res_t   o;
		rnd   = {r, 1'b0} >= {1'b0, md};
		qf    = {1'b0, q} + (QW+1)'(rnd);
		lim   = neg ? (QW+1)'(34'h0_8000_0000) : (QW+1)'(34'h0_7FFF_FFFF);
		o.sat = ovf | (qf > lim);
		mag   = o.sat ? lim : qf;
		o.val = neg ? (32'd0 - mag[31:0]) : mag[31:0];
		div_fin = o;
	endfunction

	logic signed [NUM_W-1:0] num [NLANE];
	logic [NUM_W-1:0]        mag [NLANE];
	logic [DET_W-1:0]        dm;
	logic [MD_W:0]           r0  [NLANE];

	logic [MD_W-1:0] md_s  [0:QW];
	logic [MD_W-1:0] r_s   [0:QW][NLANE];
	logic [QW-1:0]   lo_s  [0:QW][NLANE];
	logic [QW-1:0]   q_s   [0:QW][NLANE];
	logic            neg_s [0:QW][NLANE];
	logic            ovf_s [0:QW][NLANE];
	logic [31:0]     p1x_s [0:QW];
	logic [31:0]     p1y_s [0:QW];
	logic            par_s [0:QW];
	logic            v_s   [0:QW+1];
	ltx_res_t        res_s;

	function automatic ltx_res_t fin_word();
		lane_res_t lr [NLANE];
		ltx_res_t  o;
		for (int k = 0; k < NLANE; k++)
			lr[k] = div_fin(q_s[QW][k], r_s[QW][k], md_s[QW], neg_s[QW][k], ovf_s[QW][k]);
		if (par_s[QW]) begin
			o.cross_x = p1x_s[QW];
			o.cross_y = p1y_s[QW];
			o.param   = '0;
			o.par     = 1'b1;
			o.sat     = 1'b0;
		end else begin
			o.cross_x = lr[0].val;
			o.cross_y = lr[1].val;
			o.param   = lr[2].val;
			o.par     = 1'b0;
			o.sat     = lr[0].sat | lr[1].sat | lr[2].sat;
		end
		fin_word = o;
	endfunction

	assign num[0] = fr.xn;
	assign num[1] = fr.yn;
	assign num[2] = fr.mn;

	always_comb begin
		dm = fr.det[DET_W-1] ? (~fr.det + DET_W'(1)) : fr.det;
		for (int k = 0; k < NLANE; k++) begin
			mag[k] = num[k][NUM_W-1] ? (~num[k] + NUM_W'(1)) : num[k];
			r0[k]  = mag[k][NUM_W-1:QW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QW+1; i++)
				v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
			for (int i = 1; i <= QW+1; i++)
				v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			md_s[0]  <= dm[MD_W-1:0];
			p1x_s[0] <= fr.p1x;
			p1y_s[0] <= fr.p1y;
			par_s[0] <= fr.par;
			for (int k = 0; k < NLANE; k++) begin
				neg_s[0][k] <= num[k][NUM_W-1] ^ fr.det[DET_W-1];
				ovf_s[0][k] <= r0[k] >= {1'b0, dm[MD_W-1:0]};
				r_s[0][k]   <= r0[k][MD_W-1:0];
				lo_s[0][k]  <= mag[k][QW-1:0];
				q_s[0][k]   <= '0;
			end
			for (int i = 1; i <= QW; i++) begin
				md_s[i]  <= md_s[i-1];
				p1x_s[i] <= p1x_s[i-1];
				p1y_s[i] <= p1y_s[i-1];
				par_s[i] <= par_s[i-1];
				for (int k = 0; k < NLANE; k++) begin
					neg_s[i][k] <= neg_s[i-1][k];
					ovf_s[i][k] <= ovf_s[i-1][k];
					r_s[i][k]   <= div_rem(r_s[i-1][k], lo_s[i-1][k][QW-1], md_s[i-1]);
					lo_s[i][k]  <= lo_s[i-1][k] << 1;
					q_s[i][k]   <= {q_s[i-1][k][QW-2:0],
						div_ge(r_s[i-1][k], lo_s[i-1][k][QW-1], md_s[i-1])};
				end
			end
			res_s <= fin_word();
		end
	end

	assign out_v = v_s[QW+1];
	assign res   = res_s;

endmodule

FILE: hw/rtl/line_intersection_2d_top.sv
// Two-line intersection in Q16.16: top level with output register and skid word.
// Instantiates ltx_front and ltx_div; uses ltx_pkg.
//
// Accepts one word per cycle while in_stall is low; returns one result word per input,
// in order. Each word passes six front stages (products, determinant,
// adjugate, partial products, numerator sums), 35 divider stages (prep, one quotient bit
// per stage for 33 bits, round and saturate) and the output register. The whole pipeline
// advances on one enable; a single skid word behind the output register lets one more
// result land while the output is stalled, after which in_stall rises until the output
// register drains.
module line_intersection_2d_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] first_point_x,
	input  logic signed [31:0] first_point_y,
	input  logic signed [31:0] first_dir_x,
	input  logic signed [31:0] first_dir_y,
	input  logic signed [31:0] second_point_x,
	input  logic signed [31:0] second_point_y,
	input  logic signed [31:0] second_dir_x,
	input  logic signed [31:0] second_dir_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] cross_x,
	output logic signed [31:0] cross_y,
	output logic signed [31:0] second_param,
	output logic               parallel,
	output logic               saturated
);
	import ltx_pkg::*;

	logic       en;
	logic       fr_v, dv_v;
	ltx_front_t fr;
	ltx_res_t   dv;
	ltx_res_t   o_q, sk_q;
	logic       ov_q, sv_q;

	assign en       = !sv_q;
	assign in_stall = sv_q;

	ltx_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (in_valid),
		.p1x    (first_point_x),
		.p1y    (first_point_y),
		.d1x    (first_dir_x),
		.d1y    (first_dir_y),
		.p2x    (second_point_x),
		.p2y    (second_point_y),
		.d2x    (second_dir_x),
		.d2y    (second_dir_y),
		.out_v  (fr_v),
		.fr     (fr)
	);

	ltx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (fr_v),
		.fr     (fr),
		.out_v  (dv_v),
		.res    (dv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (!ov_q || !out_stall) begin
			if (sv_q) begin
				ov_q <= 1'b1;
				sv_q <= 1'b0;
			end else begin
				ov_q <= dv_v;
			end
		end else if (!sv_q && dv_v) begin
			sv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || !out_stall) begin
			if (sv_q)
				o_q <= sk_q;
			else if (dv_v)
				o_q <= dv;
		end else if (!sv_q && dv_v) begin
			sk_q <= dv;
		end
	end

	assign out_valid    = ov_q;
	assign cross_x      = o_q.cross_x;
	assign cross_y      = o_q.cross_y;
	assign second_param = o_q.param;
	assign parallel     = o_q.par;
	assign saturated    = o_q.sat;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q)
		else $error("skid word held with empty output register");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sv_q) |-> $past(out_stall) && $past(ov_q))
		else $error("skid filled without a stalled output");

	a_parallel_word: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && o_q.par |-> o_q.param == '0 && !o_q.sat)
		else $error("parallel result with nonzero parameter or saturation");

endmodule
